### hdl/cdn_pkg.sv
`timescale 1ns / 1ps
// Shared widths, calendar constants and helper functions for the date normalizer.
package cdn_pkg;

	// Field widths
	localparam int DAY_W   = 21;
	localparam int MON_W   = 13;
	localparam int YEAR_W  = 16;
	localparam int NDAY_W  = 5;
	localparam int NMON_W  = 4;
	localparam int NYEAR_W = 16;

	// Shared subtractor operand widths
	localparam int OPA_W = DAY_W;
	localparam int OPB_W = 18;

	// Calendar constants
	localparam int MONTHS_PER_YEAR = 12;
	localparam int MONTH_BLOCK     = 144;     // twelve years of months
	localparam int MONTH_BLOCK_YRS = 12;
	localparam int YEAR_BLOCK      = 4000;    // ten Gregorian cycles
	localparam int ERA_YEARS       = 400;
	localparam int ERA_DAYS        = 146097;  // days in one 400-year cycle
	localparam int COMMON_YEAR     = 365;
	localparam int CENTURY         = 100;
	localparam int LEAP_STEP       = 4;
	localparam int LEAP_FEB        = 29;
	localparam int FEBRUARY        = 2;
	localparam int MOD_W           = 9;       // width of year mod 400

	// Leap rule on the year taken mod 400
	function automatic logic is_leap(input logic [MOD_W-1:0] ymod);
		logic by_cent;
		logic by_four;
		by_cent = (ymod == MOD_W'(CENTURY)) || (ymod == MOD_W'(2 * CENTURY)) ||
		          (ymod == MOD_W'(3 * CENTURY));
		by_four = (ymod % LEAP_STEP) == '0;
		return (ymod == '0) || (!by_cent && by_four);
	endfunction

	// Month length, February taken from the leap flag
	function automatic logic [NDAY_W-1:0] days_in_month(input logic [NMON_W-1:0] m,
	                                                    input logic leap);
		logic [NDAY_W-1:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = leap ? NDAY_W'(LEAP_FEB) : 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

### hdl/cdn_raw_if.sv
`timescale 1ns / 1ps
// Input channel carrying one raw signed calendar triple.
interface cdn_raw_if;
	logic                              valid;
	logic                              ready;
	logic signed [cdn_pkg::DAY_W-1:0]  raw_day;
	logic signed [cdn_pkg::MON_W-1:0]  raw_month;
	logic signed [cdn_pkg::YEAR_W-1:0] raw_year;

	modport source (output valid, output raw_day, output raw_month, output raw_year,
	                input ready);
	modport sink   (input valid, input raw_day, input raw_month, input raw_year,
	                output ready);
endinterface

### hdl/cdn_norm_if.sv
`timescale 1ns / 1ps
// Output channel carrying one normalized Gregorian date.
interface cdn_norm_if;
	logic                         valid;
	logic                         ready;
	logic [cdn_pkg::NDAY_W-1:0]   norm_day;
	logic [cdn_pkg::NMON_W-1:0]   norm_month;
	logic [cdn_pkg::NYEAR_W-1:0]  norm_year;

	modport source (output valid, output norm_day, output norm_month, output norm_year,
	                input ready);
	modport sink   (input valid, input norm_day, input norm_month, input norm_year,
	                output ready);
endinterface

### hdl/calendar_date_normalizer_top.sv
`timescale 1ns / 1ps
// Top level of the Gregorian date normalizer: sequencer around one shared subtractor.
//
// Takes one raw (day, month, year) triple at a time, replaces each field by its
// magnitude (zero becomes one) and returns the equivalent valid Gregorian date.
// Every step is one subtraction on a single shared subtractor: months are folded
// into years 144 and then 12 at a time, the year is reduced mod 400 to drive the
// leap rule, then surplus days are removed in 400-year cycles, single years and
// finally single months. The single-year loop sets the bulk of the time from
// transfer in to result. The input is ready only while the sequencer is idle,
// so the next transfer in comes at the earliest in the cycle after the result
// is loaded; the result sits in an output register, so a new triple may be
// taken while the previous date still waits, and a finished date is held back
// until that register is free.
module calendar_date_normalizer_top (
	input  logic               clk,
	input  logic               arst_n,
	cdn_raw_if.sink            raw,
	cdn_norm_if.source         norm
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MON_BIG,
		S_MON,
		S_MOD_BIG,
		S_MOD,
		S_ERA,
		S_YEAR,
		S_MONTH
	} state_t;

	state_t                              state_q;
	logic [cdn_pkg::DAY_W-1:0]           day_q;
	logic [cdn_pkg::MON_W-1:0]           mon_q;
	logic [cdn_pkg::YEAR_W-1:0]          year_q;
	logic [cdn_pkg::YEAR_W-1:0]          ymod_q;
	logic                                out_valid_q;
	logic [cdn_pkg::NDAY_W-1:0]          out_day_q;
	logic [cdn_pkg::NMON_W-1:0]          out_mon_q;
	logic [cdn_pkg::NYEAR_W-1:0]         out_year_q;

	logic                                in_xfer;
	logic                                slot_free;
	logic                                finish;
	logic [cdn_pkg::DAY_W-1:0]           day_abs;
	logic [cdn_pkg::MON_W-1:0]           mon_abs;
	logic [cdn_pkg::YEAR_W-1:0]          year_abs;
	logic [cdn_pkg::YEAR_W-1:0]          ymod_inc;
	logic                                leap_cur;
	logic                                leap_nxt;
	logic [8:0]                          year_len;
	logic [cdn_pkg::NDAY_W-1:0]          month_len;
	logic [cdn_pkg::OPA_W-1:0]           op_a;
	logic [cdn_pkg::OPB_W-1:0]           op_b;
	logic [cdn_pkg::OPA_W:0]             diff;
	logic                                diff_nonneg;
	logic                                diff_pos;

	// Handshake
	assign raw.ready  = (state_q == S_IDLE);
	assign in_xfer    = raw.valid && raw.ready;
	assign slot_free  = !out_valid_q || norm.ready;

	assign norm.valid      = out_valid_q;
	assign norm.norm_day   = out_day_q;
	assign norm.norm_month = out_mon_q;
	assign norm.norm_year  = out_year_q;

	// Magnitudes of the raw fields; the most negative pattern maps to its magnitude
	always_comb begin
		day_abs  = raw.raw_day[cdn_pkg::DAY_W-1] ? (~raw.raw_day + 1'b1) : raw.raw_day;
		mon_abs  = raw.raw_month[cdn_pkg::MON_W-1] ? (~raw.raw_month + 1'b1)
		                                           : raw.raw_month;
		year_abs = raw.raw_year[cdn_pkg::YEAR_W-1] ? (~raw.raw_year + 1'b1)
		                                           : raw.raw_year;
	end

	// Leap flags for the current and the following year
	assign ymod_inc = (ymod_q == cdn_pkg::YEAR_W'(cdn_pkg::ERA_YEARS - 1)) ? '0
	                                                                      : ymod_q + 1'b1;
	assign leap_cur  = cdn_pkg::is_leap(ymod_q[cdn_pkg::MOD_W-1:0]);
	assign leap_nxt  = cdn_pkg::is_leap(ymod_inc[cdn_pkg::MOD_W-1:0]);
	assign month_len = cdn_pkg::days_in_month(mon_q[cdn_pkg::NMON_W-1:0], leap_cur);

	// The twelve months ahead hold February of this year only from January or February
	always_comb begin
		if (mon_q <= cdn_pkg::MON_W'(cdn_pkg::FEBRUARY)) begin
			year_len = 9'(cdn_pkg::COMMON_YEAR) + {8'b0, leap_cur};
		end else begin
			year_len = 9'(cdn_pkg::COMMON_YEAR) + {8'b0, leap_nxt};
		end
	end

	// Select operands of the shared subtractor
	always_comb begin
		op_a = day_q;
		op_b = '0;
		case (state_q)
			S_MON_BIG: begin
				op_a = cdn_pkg::OPA_W'(mon_q);
				op_b = cdn_pkg::OPB_W'(cdn_pkg::MONTH_BLOCK);
			end
			S_MON: begin
				op_a = cdn_pkg::OPA_W'(mon_q);
				op_b = cdn_pkg::OPB_W'(cdn_pkg::MONTHS_PER_YEAR);
			end
			S_MOD_BIG: begin
				op_a = cdn_pkg::OPA_W'(ymod_q);
				op_b = cdn_pkg::OPB_W'(cdn_pkg::YEAR_BLOCK);
			end
			S_MOD: begin
				op_a = cdn_pkg::OPA_W'(ymod_q);
				op_b = cdn_pkg::OPB_W'(cdn_pkg::ERA_YEARS);
			end
			S_ERA:   op_b = cdn_pkg::OPB_W'(cdn_pkg::ERA_DAYS);
			S_YEAR:  op_b = cdn_pkg::OPB_W'(year_len);
			S_MONTH: op_b = cdn_pkg::OPB_W'(month_len);
			default: op_b = '0;
		endcase
	end

	// Shared subtractor
	assign diff        = {1'b0, op_a} - (cdn_pkg::OPA_W + 1)'(op_b);
	assign diff_nonneg = !diff[cdn_pkg::OPA_W];
	assign diff_pos    = diff_nonneg && (diff != '0);

	// Hand the date over once no month is left to drop and the output is free
	assign finish = (state_q == S_MONTH) && !diff_pos && slot_free;

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			day_q       <= '0;
			mon_q       <= '0;
			year_q      <= '0;
			ymod_q      <= '0;
			out_valid_q <= 1'b0;
			out_day_q   <= '0;
			out_mon_q   <= '0;
			out_year_q  <= '0;
		end else begin
			// Load a finished date, or drop the one just taken
			if (finish) begin
				out_day_q   <= day_q[cdn_pkg::NDAY_W-1:0];
				out_mon_q   <= mon_q[cdn_pkg::NMON_W-1:0];
				out_year_q  <= year_q;
				out_valid_q <= 1'b1;
			end else if (norm.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						day_q   <= (day_abs == '0) ? cdn_pkg::DAY_W'(1) : day_abs;
						mon_q   <= (mon_abs == '0) ? cdn_pkg::MON_W'(1) : mon_abs;
						year_q  <= (year_abs == '0) ? cdn_pkg::YEAR_W'(1) : year_abs;
						state_q <= S_MON_BIG;
					end
				end
				// Fold months into years, twelve years at a time while far above range
				S_MON_BIG: begin
					if (diff_nonneg &&
					    diff[cdn_pkg::OPA_W-1:0] > cdn_pkg::OPA_W'(cdn_pkg::MONTHS_PER_YEAR)) begin
						mon_q  <= diff[cdn_pkg::MON_W-1:0];
						year_q <= year_q + cdn_pkg::YEAR_W'(cdn_pkg::MONTH_BLOCK_YRS);
					end else begin
						state_q <= S_MON;
					end
				end
				// Fold the remaining months one year at a time
				S_MON: begin
					if (diff_pos) begin
						mon_q  <= diff[cdn_pkg::MON_W-1:0];
						year_q <= year_q + 1'b1;
					end else begin
						ymod_q  <= year_q;
						state_q <= S_MOD_BIG;
					end
				end
				// Reduce the year mod 400 for the leap rule
				S_MOD_BIG: begin
					if (diff_nonneg) begin
						ymod_q <= diff[cdn_pkg::YEAR_W-1:0];
					end else begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (diff_nonneg) begin
						ymod_q <= diff[cdn_pkg::YEAR_W-1:0];
					end else begin
						state_q <= S_ERA;
					end
				end
				// Drop whole 400-year cycles; the leap phase is unchanged
				S_ERA: begin
					if (diff_pos) begin
						day_q  <= diff[cdn_pkg::DAY_W-1:0];
						year_q <= year_q + cdn_pkg::YEAR_W'(cdn_pkg::ERA_YEARS);
					end else begin
						state_q <= S_YEAR;
					end
				end
				// Drop the twelve months ahead while the days cover them all
				S_YEAR: begin
					if (diff_pos) begin
						day_q  <= diff[cdn_pkg::DAY_W-1:0];
						year_q <= year_q + 1'b1;
						ymod_q <= ymod_inc;
					end else begin
						state_q <= S_MONTH;
					end
				end
				// Drop single months, then go idle once the date is handed over
				S_MONTH: begin
					if (diff_pos) begin
						day_q <= diff[cdn_pkg::DAY_W-1:0];
						if (mon_q == cdn_pkg::MON_W'(cdn_pkg::MONTHS_PER_YEAR)) begin
							mon_q  <= cdn_pkg::MON_W'(1);
							year_q <= year_q + 1'b1;
							ymod_q <= ymod_inc;
						end else begin
							mon_q <= mon_q + 1'b1;
						end
					end else if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A transfer in always starts the sequencer
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == S_MON_BIG))
		else $error("sequencer did not start after input transfer");

	// Month stays in range once the day phases run
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERA || state_q == S_YEAR || state_q == S_MONTH) |->
		(mon_q >= cdn_pkg::MON_W'(1) &&
		 mon_q <= cdn_pkg::MON_W'(cdn_pkg::MONTHS_PER_YEAR)))
		else $error("month out of range during day reduction");

	// Leap phase is a true residue mod 400 during the day phases
	a_ymod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERA || state_q == S_YEAR || state_q == S_MONTH) |->
		(ymod_q < cdn_pkg::YEAR_W'(cdn_pkg::ERA_YEARS)))
		else $error("year residue out of range");

	// A presented date has a nonzero day and a month in range
	a_out_valid_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_day_q != '0 && out_mon_q != '0 &&
		                 out_mon_q <= cdn_pkg::NMON_W'(cdn_pkg::MONTHS_PER_YEAR)))
		else $error("output date out of range");

endmodule

### tb/calendar_date_normalizer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the date normalizer: directed table, then random triples.
module calendar_date_normalizer_top_tb;
	import cdn_pkg::*;

	localparam int RANDOM_ITEMS = 558;
	localparam int QUIET_TAIL   = 60;
	localparam int HOLD_AT      = 150;
	localparam int LONG_HOLD    = 600;
	localparam int DRAIN_CYCLES = 600;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [NDAY_W-1:0]  day;
		logic [NMON_W-1:0]  month;
		logic [NYEAR_W-1:0] year;
	} date_t;

	typedef struct packed {
		logic signed [DAY_W-1:0]  day;
		logic signed [MON_W-1:0]  month;
		logic signed [YEAR_W-1:0] year;
		logic                     known;
		date_t                    want;
	} stim_t;

	logic clk;
	logic arst_n;
	logic quiet;
	logic hold_done;
	int   sent_count  = 0;
	int   mismatches  = 0;
	int   cycle_count = 0;

	date_t pending_dates[$];
	stim_t directed_rows[$];

	cdn_raw_if  raw_ch();
	cdn_norm_if norm_ch();

	calendar_date_normalizer_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_ch),
		.norm   (norm_ch)
	);

	// Free-running clock, 2 ns period
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Gregorian leap rule
	function automatic logic leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
		case (m)
			2:           return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// Absolute value, zero taken as one
	function automatic int unsigned magnitude(input int v);
		if (v == 0)
			return 1;
		return (v < 0) ? -v : v;
	endfunction

	function automatic date_t normalize_date(input logic signed [DAY_W-1:0] rd,
	                                         input logic signed [MON_W-1:0] rm,
	                                         input logic signed [YEAR_W-1:0] ry);
		int unsigned d;
		int unsigned m;
		int unsigned y;
		int unsigned len;
		date_t r;
		d = magnitude(rd);
		m = magnitude(rm);
		y = magnitude(ry);
		// fold surplus months into the year
		y += (m - 1) / 12;
		m = (m - 1) % 12 + 1;
		// the calendar repeats every 400 years, so skip whole cycles at once
		while (d > ERA_DAYS) begin
			d -= ERA_DAYS;
			y += ERA_YEARS;
		end
		// remove the remaining surplus one month at a time
		len = month_length(m, y);
		while (d > len) begin
			d -= len;
			m++;
			if (m > 12) begin
				m = 1;
				y++;
			end
			len = month_length(m, y);
		end
		r.day   = NDAY_W'(d);
		r.month = NMON_W'(m);
		r.year  = NYEAR_W'(y);
		return r;
	endfunction

	function automatic stim_t row(input int d, input int m, input int y, input logic known,
	                              input int wd, input int wm, input int wy);
		stim_t s;
		s.day        = DAY_W'(d);
		s.month      = MON_W'(m);
		s.year       = YEAR_W'(y);
		s.known      = known;
		s.want.day   = NDAY_W'(wd);
		s.want.month = NMON_W'(wm);
		s.want.year  = NYEAR_W'(wy);
		return s;
	endfunction

	function automatic int corner_value(input int width, input int sel);
		case (sel)
			0:       return 0;
			1:       return 1;
			2:       return -1;
			3:       return (1 << (width - 1)) - 1;
			default: return -(1 << (width - 1));
		endcase
	endfunction

	// Offer one triple, hold it until the transfer, then log its expected date
	task automatic send_triple(input stim_t s);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			raw_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		raw_ch.valid     <= 1'b1;
		raw_ch.raw_day   <= s.day;
		raw_ch.raw_month <= s.month;
		raw_ch.raw_year  <= s.year;
		@(posedge clk);
		while (!raw_ch.ready)
			@(posedge clk);
		pending_dates.push_back(s.known ? s.want : normalize_date(s.day, s.month, s.year));
		sent_count++;
	endtask

	// Sender: reset, directed table, random triples, drain
	initial begin
		stim_t s;
		int    pick;
		raw_ch.valid     <= 1'b0;
		raw_ch.raw_day   <= '0;
		raw_ch.raw_month <= '0;
		raw_ch.raw_year  <= '0;
		arst_n           <= 1'b0;
		quiet = 1'b0;

		// zero fields and plain values
		directed_rows.push_back(row(0, 0, 0, 1'b1, 1, 1, 1));
		directed_rows.push_back(row(1, 1, 1, 1'b1, 1, 1, 1));
		directed_rows.push_back(row(-1, -1, -1, 1'b1, 1, 1, 1));
		directed_rows.push_back(row(-31, -12, -2023, 1'b1, 31, 12, 2023));
		// month ends and year roll-over
		directed_rows.push_back(row(30, 4, 1, 1'b1, 30, 4, 1));
		directed_rows.push_back(row(31, 4, 1, 1'b1, 1, 5, 1));
		directed_rows.push_back(row(31, 12, 9999, 1'b1, 31, 12, 9999));
		directed_rows.push_back(row(32, 12, 9999, 1'b1, 1, 1, 10000));
		// leap rule: by 400, by 4, not by 100, common year
		directed_rows.push_back(row(29, 2, 2000, 1'b1, 29, 2, 2000));
		directed_rows.push_back(row(29, 2, 2024, 1'b1, 29, 2, 2024));
		directed_rows.push_back(row(29, 2, 1900, 1'b1, 1, 3, 1900));
		directed_rows.push_back(row(29, 2, 2023, 1'b1, 1, 3, 2023));
		directed_rows.push_back(row(28, 2, 2023, 1'b1, 28, 2, 2023));
		directed_rows.push_back(row(366, 1, 2000, 1'b1, 31, 12, 2000));
		directed_rows.push_back(row(366, 1, 2001, 1'b1, 1, 1, 2002));
		// month carry into the year
		directed_rows.push_back(row(1, 13, 1, 1'b1, 1, 1, 2));
		directed_rows.push_back(row(1, 24, 1, 1'b1, 1, 12, 2));
		directed_rows.push_back(row(1, 4095, 1, 1'b1, 1, 3, 342));
		// most negative patterns and the largest year
		directed_rows.push_back(row(1, -4096, 1, 1'b1, 1, 4, 342));
		directed_rows.push_back(row(1, 1, -32768, 1'b1, 1, 1, 32768));
		directed_rows.push_back(row(1, 1, 32767, 1'b1, 1, 1, 32767));
		// long day counts, checked by the predictor
		directed_rows.push_back(row(1048575, 1, 1, 1'b0, 0, 0, 0));
		directed_rows.push_back(row(-1048576, -4096, -32768, 1'b0, 0, 0, 0));
		directed_rows.push_back(row(1048575, 4095, 32767, 1'b0, 0, 0, 0));
		directed_rows.push_back(row(400, -7, 2024, 1'b0, 0, 0, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_triple(directed_rows[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= RANDOM_ITEMS - QUIET_TAIL);
			pick  = $urandom_range(0, 9);
			case (pick)
				// any bit pattern
				0, 1: begin
					s.day   = DAY_W'($urandom);
					s.month = MON_W'($urandom);
					s.year  = YEAR_W'($urandom);
				end
				// short spans from any year
				2, 3, 4: begin
					s.day   = DAY_W'($urandom_range(0, 400));
					s.month = MON_W'($urandom_range(0, 30));
					s.year  = YEAR_W'($urandom_range(0, 32767));
				end
				// around month ends in century and leap years
				5, 6: begin
					s.day   = DAY_W'($urandom_range(27, 32));
					s.month = MON_W'($urandom_range(1, 12));
					s.year  = YEAR_W'(100 * $urandom_range(1, 327) + $urandom_range(0, 8));
				end
				// spans of one or two 400-year cycles
				7: begin
					s.day   = DAY_W'($urandom_range(0, 2 * ERA_DAYS));
					s.month = MON_W'($urandom_range(1, 12));
					s.year  = YEAR_W'($urandom_range(1, 32767));
				end
				// field corners
				8: begin
					s.day   = DAY_W'(corner_value(DAY_W, $urandom_range(0, 4)));
					s.month = MON_W'(corner_value(MON_W, $urandom_range(0, 4)));
					s.year  = YEAR_W'(corner_value(YEAR_W, $urandom_range(0, 4)));
				end
				default: begin
					s.day   = DAY_W'($urandom_range(0, 2000));
					s.month = MON_W'($urandom_range(0, 4095));
					s.year  = YEAR_W'($urandom_range(0, 3000));
				end
			endcase
			// flip signs now and then
			if ($urandom_range(0, 3) == 0)
				s.day = -s.day;
			if ($urandom_range(0, 3) == 0)
				s.month = -s.month;
			if ($urandom_range(0, 3) == 0)
				s.year = -s.year;
			s.known = 1'b0;
			s.want  = '0;
			send_triple(s);
		end
		raw_ch.valid <= 1'b0;

		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Receiver: one long hold-off to back the block up, short random stalls otherwise
	initial begin
		norm_ch.ready <= 1'b0;
		hold_done = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!hold_done && sent_count >= HOLD_AT) begin
				norm_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				norm_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				norm_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare each result transfer with the oldest expected date
	always @(posedge clk) begin
		date_t got;
		date_t want;
		logic  bad;
		if (arst_n && norm_ch.valid && norm_ch.ready) begin
			got.day   = norm_ch.norm_day;
			got.month = norm_ch.norm_month;
			got.year  = norm_ch.norm_year;
			bad       = 1'b0;
			want      = '0;
			if (pending_dates.size() == 0) begin
				bad = 1'b1;
			end else begin
				want = pending_dates.pop_front();
				bad  = (got.day != want.day) || (got.month != want.month) ||
				       (got.year != want.year);
			end
			if (bad) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch at cycle %0d: expected %0d-%0d-%0d got %0d-%0d-%0d%s",
					         cycle_count, want.year, want.month, want.day,
					         got.year, got.month, got.day,
					         (pending_dates.size() == 0 && want == '0) ? " (none pending)" : "");
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule

### files.f
hdl/cdn_pkg.sv
hdl/cdn_raw_if.sv
hdl/cdn_norm_if.sv
hdl/calendar_date_normalizer_top.sv
tb/calendar_date_normalizer_top_tb.sv
